>>> hw/rtl/jtl_pkg.sv
// Shared types, codes and character helpers for the JSON token lexer.
package jtl_pkg;

    localparam int POS_BITS = 16;

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [POS_BITS:0]   pos_ext_t;

    // token kinds as they appear on the result channel
    localparam logic [3:0] KIND_END    = 4'd0;
    localparam logic [3:0] KIND_ERROR  = 4'd1;
    localparam logic [3:0] KIND_TRUE   = 4'd2;
    localparam logic [3:0] KIND_STRING = 4'd5;
    localparam logic [3:0] KIND_NUMBER = 4'd6;
    localparam logic [3:0] KIND_COMMA  = 4'd7;
    localparam logic [3:0] KIND_COLON  = 4'd8;
    localparam logic [3:0] KIND_LBRACE = 4'd9;
    localparam logic [3:0] KIND_RBRACE = 4'd10;
    localparam logic [3:0] KIND_LBRACK = 4'd11;
    localparam logic [3:0] KIND_RBRACK = 4'd12;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef enum logic [15:0] {
        MD_IDLE          = 16'b0000_0000_0000_0001,
        MD_SLASH         = 16'b0000_0000_0000_0010,
        MD_LINE          = 16'b0000_0000_0000_0100,
        MD_BLOCK         = 16'b0000_0000_0000_1000,
        MD_BLOCK_STAR    = 16'b0000_0000_0001_0000,
        MD_KW            = 16'b0000_0000_0010_0000,
        MD_STR           = 16'b0000_0000_0100_0000,
        MD_STR_ESC       = 16'b0000_0000_1000_0000,
        MD_STR_HEX       = 16'b0000_0001_0000_0000,
        MD_NUM_SIGN      = 16'b0000_0010_0000_0000,
        MD_NUM_INT       = 16'b0000_0100_0000_0000,
        MD_NUM_FRAC_NEED = 16'b0000_1000_0000_0000,
        MD_NUM_FRAC      = 16'b0001_0000_0000_0000,
        MD_NUM_EXP_SIGN  = 16'b0010_0000_0000_0000,
        MD_NUM_EXP_NEED  = 16'b0100_0000_0000_0000,
        MD_NUM_EXP       = 16'b1000_0000_0000_0000
    } mode_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // keyword spelling: 0 true, 1 false, 2 null
    function automatic logic [2:0] kw_len(input logic [1:0] w);
        logic [2:0] r;
        unique case (w)
            2'd0:    r = 3'd4;
            2'd1:    r = 3'd5;
            2'd2:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] off);
        logic [7:0] r;
        r = 8'h00;
        unique case (w)
            2'd0: begin
                unique case (off)
                    3'd0: r = 8'h74;  // t
                    3'd1: r = 8'h72;  // r
                    3'd2: r = 8'h75;  // u
                    3'd3: r = 8'h65;  // e
                    default: r = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (off)
                    3'd0: r = 8'h66;  // f
                    3'd1: r = 8'h61;  // a
                    3'd2: r = 8'h6C;  // l
                    3'd3: r = 8'h73;  // s
                    3'd4: r = 8'h65;  // e
                    default: r = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (off)
                    3'd0: r = 8'h6E;  // n
                    3'd1: r = 8'h75;  // u
                    3'd2: r = 8'h6C;  // l
                    3'd3: r = 8'h6C;  // l
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // length from..to, zero when reversed, saturated to 16 bits
    function automatic logic [15:0] span_len(input pos_ext_t from, input pos_ext_t to);
        pos_ext_t d;
        d = (to >= from) ? (to - from) : '0;
        if ((POS_BITS+17)'(d) > (POS_BITS+17)'(LEN_MAX)) begin
            return LEN_MAX;
        end
        return 16'(d);
    endfunction

endpackage

>>> hw/rtl/json_token_lexer.sv
// Streaming JSON tokenizer: one text byte per transaction, tokens out.
//
//  channel | direction | payload                                   | handshake
//  s_      | in        | byte_present, text_byte, is_last          | s_valid / s_ready
//  m_      | out       | token_kind, token_start, token_length,    | m_valid / m_ready
//          |           | last_of_run                               |
//
// One input transaction per clock: the lexer state updates in the accept cycle and
// the zero to three tokens it causes land in an 8-entry result queue.
// The queue drains one token per clock; s_ready drops while it holds more than
// five tokens, so only bursts of multi-token bytes or a stalled m_ready slow input.
// A result is registered into the queue when its byte is accepted and shows on m_ once the tokens ahead of it drain.
// Reset (aresetn low at a clock edge) returns to the start of a text and empties
// the queue; no clearing pass is needed.
module json_token_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_byte_present,
    input  logic [7:0]  s_text_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [15:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic        m_last_of_run
);
    import jtl_pkg::*;

    localparam int QDEPTH = 8;
    localparam int QPTR   = $clog2(QDEPTH);
    localparam int MAX_RES = 3;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam pos_t       POS_MAX   = '1;

    // lexer state
    mode_t       mode_reg, mode_next;
    pos_t        pos_reg, pos_next;
    pos_t        tb_reg, tb_next;      // token begin
    pos_t        cb_reg, cb_next;      // comment begin
    logic [1:0]  kw_reg, kw_next;      // which keyword
    logic        km_reg, km_next;      // keyword still matching
    logic [2:0]  hex_reg, hex_next;    // \u digits still owed
    logic        halt_reg, halt_next;  // text halted after an error

    // result queue
    token_t            q_mem [QDEPTH];
    logic [QPTR-1:0]   rd_ptr_reg, wr_ptr_reg;
    logic [QPTR:0]     cnt_reg, cnt_next;

    // step outputs
    logic [3:0]  res_kind  [MAX_RES+1];
    logic [15:0] res_start [MAX_RES+1];
    logic [15:0] res_len   [MAX_RES+1];
    logic [1:0]  n_res;

    logic [7:0]  c;
    pos_t        p, p_end, kw_off, kw_off_end, hex_stop;
    logic [2:0]  hex_back, hex_back_end;
    logic        do_byte, ended, relex;
    logic        s_fire, m_fire;

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign s_ready = (cnt_reg <= (QPTR+1)'(QDEPTH - MAX_RES));
    assign m_valid = (cnt_reg != '0);

    assign m_token_kind   = q_mem[rd_ptr_reg].kind;
    assign m_token_start  = q_mem[rd_ptr_reg].start;
    assign m_token_length = q_mem[rd_ptr_reg].length;
    assign m_last_of_run  = q_mem[rd_ptr_reg].last;

    assign c          = s_text_byte;
    assign p          = pos_reg;
    assign do_byte    = s_byte_present && (c != 8'h00);
    assign ended      = !s_byte_present || (c == 8'h00) || s_is_last;
    assign kw_off     = p - tb_reg;
    assign p_end      = (do_byte && (pos_reg != POS_MAX)) ? pos_reg + 1'b1 : pos_reg;
    // \u failure spans the bytes before the 'u'
    assign hex_back   = (hex_reg <= 3'd4) ? 3'd5 - hex_reg : 3'd1;

    always_comb begin
        mode_next    = mode_reg;
        pos_next     = p_end;
        tb_next      = tb_reg;
        cb_next      = cb_reg;
        kw_next      = kw_reg;
        km_next      = km_reg;
        hex_next     = hex_reg;
        halt_next    = halt_reg;
        relex        = 1'b0;
        n_res        = 2'd0;
        kw_off_end   = '0;
        hex_stop     = '0;
        hex_back_end = 3'd1;
        for (int i = 0; i <= MAX_RES; i++) begin
            res_kind[i]  = KIND_END;
            res_start[i] = '0;
            res_len[i]   = '0;
        end

        // ---- lex the byte against the pending token ----
        if (do_byte && !halt_reg) begin
            unique case (mode_reg)
                MD_KW: begin
                    if (is_alnum(c)) begin
                        if ((kw_off < POS_BITS'(kw_len(kw_reg))) &&
                            (c != kw_char(kw_reg, kw_off[2:0]))) begin
                            km_next = 1'b0;
                        end
                    end else if (km_reg && (kw_off == POS_BITS'(kw_len(kw_reg)))) begin
                        res_kind[n_res]  = KIND_TRUE + 4'(kw_reg);
                        res_start[n_res] = 16'(tb_reg);
                        res_len[n_res]   = span_len({1'b0, tb_reg}, {1'b0, p});
                        n_res            = n_res + 2'd1;
                        relex            = 1'b1;
                    end else begin
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(tb_reg);
                        res_len[n_res]   = span_len({1'b0, tb_reg}, {1'b0, p});
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                        mode_next        = MD_IDLE;
                    end
                end
                MD_NUM_SIGN, MD_NUM_FRAC_NEED, MD_NUM_EXP_NEED, MD_NUM_EXP_SIGN: begin
                    if (is_digit(c)) begin
                        priority if (mode_reg == MD_NUM_SIGN)      mode_next = MD_NUM_INT;
                        else if (mode_reg == MD_NUM_FRAC_NEED)     mode_next = MD_NUM_FRAC;
                        else                                       mode_next = MD_NUM_EXP;
                    end else if ((mode_reg == MD_NUM_EXP_SIGN) &&
                                 ((c == CH_PLUS) || (c == CH_MINUS))) begin
                        mode_next = MD_NUM_EXP_NEED;
                    end else begin
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(tb_reg);
                        res_len[n_res]   = span_len({1'b0, tb_reg}, {1'b0, p});
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                        mode_next        = MD_IDLE;
                    end
                end
                MD_NUM_INT, MD_NUM_FRAC, MD_NUM_EXP: begin
                    if (is_digit(c)) begin
                        mode_next = mode_reg;
                    end else if ((mode_reg == MD_NUM_INT) && (c == CH_DOT)) begin
                        mode_next = MD_NUM_FRAC_NEED;
                    end else if ((mode_reg != MD_NUM_EXP) &&
                                 ((c == CH_LO_E) || (c == CH_UP_E))) begin
                        mode_next = MD_NUM_EXP_SIGN;
                    end else begin
                        res_kind[n_res]  = KIND_NUMBER;
                        res_start[n_res] = 16'(tb_reg);
                        res_len[n_res]   = span_len({1'b0, tb_reg}, {1'b0, p});
                        n_res            = n_res + 2'd1;
                        relex            = 1'b1;
                    end
                end
                MD_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode_next = MD_LINE;
                    end else if (c == CH_STAR) begin
                        mode_next = MD_BLOCK;
                    end else begin
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(cb_reg);
                        res_len[n_res]   = '0;
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                        mode_next        = MD_IDLE;
                    end
                end
                MD_LINE: begin
                    if ((c == CH_CR) || (c == CH_LF)) mode_next = MD_IDLE;
                end
                MD_BLOCK: begin
                    if (c == CH_STAR) mode_next = MD_BLOCK_STAR;
                end
                MD_BLOCK_STAR: begin
                    if (c == CH_SLASH)     mode_next = MD_IDLE;
                    else if (c != CH_STAR) mode_next = MD_BLOCK;
                end
                MD_STR: begin
                    if (c == CH_QUOTE) begin
                        res_kind[n_res]  = KIND_STRING;
                        res_start[n_res] = 16'(tb_reg);
                        res_len[n_res]   = span_len({1'b0, tb_reg}, {1'b0, p} + 1'b1);
                        n_res            = n_res + 2'd1;
                        mode_next        = MD_IDLE;
                    end else if (c == CH_BSLASH) begin
                        mode_next = MD_STR_ESC;
                    end else if (c < CH_SPACE) begin
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(tb_reg);
                        res_len[n_res]   = span_len({1'b0, tb_reg}, {1'b0, p});
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                        mode_next        = MD_IDLE;
                    end
                end
                MD_STR_ESC: begin
                    if ((c == CH_QUOTE) || (c == CH_BSLASH) || (c == CH_SLASH) ||
                        (c == 8'h62) || (c == 8'h66) || (c == 8'h6E) ||
                        (c == 8'h72) || (c == 8'h74)) begin
                        mode_next = MD_STR;
                    end else if (c == 8'h75) begin
                        hex_next  = 3'd4;
                        mode_next = MD_STR_HEX;
                    end else begin
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(tb_reg);
                        res_len[n_res]   = span_len({1'b0, tb_reg}, {1'b0, p});
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                        mode_next        = MD_IDLE;
                    end
                end
                MD_STR_HEX: begin
                    if (is_hex(c) && (hex_reg >= 3'd1) && (hex_reg <= 3'd4)) begin
                        hex_next = hex_reg - 3'd1;
                        if (hex_reg == 3'd1) mode_next = MD_STR;
                    end else begin
                        hex_stop = (p >= POS_BITS'(hex_back)) ? p - POS_BITS'(hex_back) : '0;
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(tb_reg);
                        res_len[n_res]   = span_len({1'b0, tb_reg}, {1'b0, hex_stop});
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                        mode_next        = MD_IDLE;
                    end
                end
                default: begin
                    relex = 1'b1;
                end
            endcase

            // ---- lex the byte as the start of a new token ----
            if (relex) begin
                mode_next = MD_IDLE;
                if (!is_space(c)) begin
                    priority if (c == CH_SLASH) begin
                        cb_next   = p;
                        mode_next = MD_SLASH;
                    end else if ((c == 8'h74) || (c == 8'h66) || (c == 8'h6E)) begin
                        tb_next   = p;
                        kw_next   = (c == 8'h74) ? 2'd0 : (c == 8'h66) ? 2'd1 : 2'd2;
                        km_next   = 1'b1;
                        mode_next = MD_KW;
                    end else if (c == CH_QUOTE) begin
                        tb_next   = p;
                        mode_next = MD_STR;
                    end else if (c == CH_MINUS) begin
                        tb_next   = p;
                        mode_next = MD_NUM_SIGN;
                    end else if ((c == 8'h2C) || (c == 8'h3A) || (c == 8'h7B) ||
                                 (c == 8'h7D) || (c == 8'h5B) || (c == 8'h5D)) begin
                        priority if (c == 8'h2C) res_kind[n_res] = KIND_COMMA;
                        else if (c == 8'h3A)     res_kind[n_res] = KIND_COLON;
                        else if (c == 8'h7B)     res_kind[n_res] = KIND_LBRACE;
                        else if (c == 8'h7D)     res_kind[n_res] = KIND_RBRACE;
                        else if (c == 8'h5B)     res_kind[n_res] = KIND_LBRACK;
                        else                     res_kind[n_res] = KIND_RBRACK;
                        res_start[n_res] = 16'(p);
                        res_len[n_res]   = span_len({1'b0, p}, {1'b0, p} + 1'b1);
                        n_res            = n_res + 2'd1;
                    end else if (is_digit(c)) begin
                        tb_next   = p;
                        mode_next = MD_NUM_INT;
                    end else begin
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(p);
                        res_len[n_res]   = '0;
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                        mode_next        = MD_IDLE;
                    end
                end
            end
        end

        // ---- end of text: close the pending token, emit end unless halted, rewind ----
        if (ended) begin
            if (!halt_next) begin
                kw_off_end   = p_end - tb_next;
                // digits still owed after this byte set how far back a short \u fails
                hex_back_end = (hex_next <= 3'd4) ? 3'd5 - hex_next : 3'd1;
                hex_stop     = (p_end >= POS_BITS'(hex_back_end)) ?
                               p_end - POS_BITS'(hex_back_end) : '0;
                unique case (mode_next)
                    MD_KW: begin
                        if (km_next && (kw_off_end == POS_BITS'(kw_len(kw_next)))) begin
                            res_kind[n_res] = KIND_TRUE + 4'(kw_next);
                        end else begin
                            res_kind[n_res] = KIND_ERROR;
                            halt_next       = 1'b1;
                        end
                        res_start[n_res] = 16'(tb_next);
                        res_len[n_res]   = span_len({1'b0, tb_next}, {1'b0, p_end});
                        n_res            = n_res + 2'd1;
                    end
                    MD_NUM_INT, MD_NUM_FRAC, MD_NUM_EXP: begin
                        res_kind[n_res]  = KIND_NUMBER;
                        res_start[n_res] = 16'(tb_next);
                        res_len[n_res]   = span_len({1'b0, tb_next}, {1'b0, p_end});
                        n_res            = n_res + 2'd1;
                    end
                    MD_NUM_SIGN, MD_NUM_FRAC_NEED, MD_NUM_EXP_SIGN, MD_NUM_EXP_NEED,
                    MD_STR, MD_STR_ESC: begin
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(tb_next);
                        res_len[n_res]   = span_len({1'b0, tb_next}, {1'b0, p_end});
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                    end
                    MD_STR_HEX: begin
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(tb_next);
                        res_len[n_res]   = span_len({1'b0, tb_next}, {1'b0, hex_stop});
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                    end
                    MD_SLASH, MD_BLOCK, MD_BLOCK_STAR: begin
                        res_kind[n_res]  = KIND_ERROR;
                        res_start[n_res] = 16'(cb_next);
                        res_len[n_res]   = '0;
                        n_res            = n_res + 2'd1;
                        halt_next        = 1'b1;
                    end
                    default: begin
                        halt_next = halt_next;
                    end
                endcase
                if (!halt_next) begin
                    res_kind[n_res]  = KIND_END;
                    res_start[n_res] = 16'(p_end);
                    res_len[n_res]   = '0;
                    n_res            = n_res + 2'd1;
                end
            end
            // rewind for the next text
            mode_next = MD_IDLE;
            pos_next  = '0;
            tb_next   = '0;
            cb_next   = '0;
            kw_next   = '0;
            km_next   = 1'b0;
            hex_next  = '0;
            halt_next = 1'b0;
        end
    end

    // advance the lexer state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MD_IDLE;
            pos_reg  <= '0;
            tb_reg   <= '0;
            cb_reg   <= '0;
            kw_reg   <= '0;
            km_reg   <= 1'b0;
            hex_reg  <= '0;
            halt_reg <= 1'b0;
        end else if (s_fire) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            tb_reg   <= tb_next;
            cb_reg   <= cb_next;
            kw_reg   <= kw_next;
            km_reg   <= km_next;
            hex_reg  <= hex_next;
            halt_reg <= halt_next;
        end
    end

    // push up to three tokens per transaction; flag the final one of the run
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < MAX_RES; i++) begin
                if (2'(i) < n_res) begin
                    q_mem[wr_ptr_reg + QPTR'(i)] <= '{kind:   res_kind[i],
                                                       start:  res_start[i],
                                                       length: res_len[i],
                                                       last:   (2'(i) == n_res - 2'd1)};
                end
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (s_fire) cnt_next = cnt_next + (QPTR+1)'(n_res);
        if (m_fire) cnt_next = cnt_next - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (s_fire) wr_ptr_reg <= wr_ptr_reg + QPTR'(n_res);
            if (m_fire) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/jtl_checker.sv
// Port-level checks for the JSON token lexer, bound onto the top level.
module jtl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_token_kind,
    input logic [15:0] m_token_start,
    input logic [15:0] m_token_length,
    input logic        m_last_of_run
);
    import jtl_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) &&
        $stable(m_token_start) && $stable(m_token_length) && $stable(m_last_of_run))
        else $error("stalled result changed");

    // end token is empty and closes its run
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == KIND_END) |-> (m_token_length == 16'd0) && m_last_of_run)
        else $error("bad end token");

    // punctuation covers exactly one byte
    a_punct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_token_kind == KIND_COMMA) || (m_token_kind == KIND_COLON) ||
                    (m_token_kind == KIND_LBRACE) || (m_token_kind == KIND_RBRACE) ||
                    (m_token_kind == KIND_LBRACK) || (m_token_kind == KIND_RBRACK))
        |-> (m_token_length == 16'd1))
        else $error("punctuation length not one");

    // an error halts the text, so nothing follows it in the same run
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == KIND_ERROR) |-> m_last_of_run)
        else $error("error token not last of run");

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_token_kind   (m_token_kind),
    .m_token_start  (m_token_start),
    .m_token_length (m_token_length),
    .m_last_of_run  (m_last_of_run)
);
